[src/nhns_pkg.sv]
// shared types and constants for the nearest hit name selector
package nhns_pkg;

  localparam int MAX_PREFIX  = 6;
  localparam int WORD_W      = 32;
  localparam int POS_W       = 3;
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;

  // register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_PREFIX_LENGTH = 3'd0;
  localparam logic [2:0] REG_PREFIX_NAME_0 = 3'd1;
  localparam logic [2:0] REG_PREFIX_NAME_1 = 3'd2;
  localparam logic [2:0] REG_PREFIX_NAME_2 = 3'd3;
  localparam logic [2:0] REG_PREFIX_NAME_3 = 3'd4;
  localparam logic [2:0] REG_PREFIX_NAME_4 = 3'd5;
  localparam logic [2:0] REG_PREFIX_NAME_5 = 3'd6;

  typedef enum logic [1:0] {
    PH_COUNT = 2'd0,
    PH_MIN   = 2'd1,
    PH_MAX   = 2'd2,
    PH_NAMES = 2'd3
  } phase_t;

  typedef struct packed {
    logic [POS_W-1:0]                   prefix_length;
    logic [MAX_PREFIX-1:0][WORD_W-1:0]  prefix_name;
  } cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] selected_name;
    logic              match_found;
  } result_t;

endpackage

[src/nearest_hit_name_selector.sv]
// top level of the nearest hit name selector
//
// the slave stream carries the selection buffer one 32-bit word per transfer,
// s_tlast marking the final word. words form hit records: name count, min
// depth, max depth, then the names. a hit qualifies when its leading names
// equal the configured prefix and it holds one more name, the candidate.
// on the final word one transfer leaves on the master stream: m_tdata is the
// candidate of the qualifying hit with the smallest min depth (earliest wins
// ties), 0 if none; m_tuser is the found flag.
// a word sits in the input register and is folded into the scan state by the
// parser logic, while the result of a final word loads the result register,
// which drives m_tvalid and the master stream.
// throughput: one word per cycle while no final word waits on a stalled receiver.
// when the receiver stalls, the result register holds; non-final words keep
// flowing, a final word waits in the input register until the result
// register frees. prefix registers sit on the apb port; the user must write them
// only while idle, and the block does not enforce it. reset clears the valid bits
// of both stream registers, the scan state and all prefix registers.
module nearest_hit_name_selector (
  input  logic                          clk,
  input  logic                          rst,
  // slave stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [nhns_pkg::WORD_W-1:0]   s_tdata,   // [31:0] buffer_word
  input  logic                          s_tlast,   // end_of_buffer
  // master stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [nhns_pkg::WORD_W-1:0]   m_tdata,   // [31:0] selected_name
  output logic                          m_tuser,   // [0] match_found
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nhns_pkg::PADDR_W-1:0]  paddr,
  input  logic [nhns_pkg::PDATA_W-1:0]  pwdata,
  output logic [nhns_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import nhns_pkg::*;

  cfg_t              cfg;
  result_t           result;
  logic              result_valid;

  // input register
  logic              in_valid;
  logic [WORD_W-1:0] in_word;
  logic              in_last;
  logic              advance;

  // a final word needs a free result register, other words always move on
  assign advance  = in_valid & (~in_last | ~m_tvalid | m_tready);
  assign s_tready = ~in_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_word <= s_tdata;
      in_last <= s_tlast;
    end
  end

  nhns_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  nhns_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .word_valid   (advance),
    .word         (in_word),
    .word_last    (in_last),
    .result_valid (result_valid),
    .result       (result)
  );

  nhns_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (result_valid),
    .result   (result),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // a final word that leaves the input register always produces a result
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance && in_last |=> m_tvalid)
    else $error("final word did not produce a result");

  // a waiting word is neither dropped nor overwritten
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_word) && $stable(in_last))
    else $error("input register lost a waiting word");

  // no hit means a zero name
  a_no_hit_zero_name: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("nonzero name without a qualifying hit");

endmodule

[src/nhns_cfg.sv]
// apb register file holding the prefix length and prefix names
module nhns_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nhns_pkg::PADDR_W-1:0]  paddr,
  input  logic [nhns_pkg::PDATA_W-1:0]  pwdata,
  output logic [nhns_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output nhns_pkg::cfg_t                cfg
);
  import nhns_pkg::*;

  logic [2:0] reg_index;
  logic       write_en;

  assign reg_index = paddr[PADDR_W-1:2];
  assign pready    = 1'b1;
  assign write_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (write_en) begin
      case (reg_index)
        REG_PREFIX_LENGTH: cfg.prefix_length  <= pwdata[POS_W-1:0];
        REG_PREFIX_NAME_0: cfg.prefix_name[0] <= pwdata;
        REG_PREFIX_NAME_1: cfg.prefix_name[1] <= pwdata;
        REG_PREFIX_NAME_2: cfg.prefix_name[2] <= pwdata;
        REG_PREFIX_NAME_3: cfg.prefix_name[3] <= pwdata;
        REG_PREFIX_NAME_4: cfg.prefix_name[4] <= pwdata;
        REG_PREFIX_NAME_5: cfg.prefix_name[5] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_PREFIX_LENGTH: prdata = {{(PDATA_W-POS_W){1'b0}}, cfg.prefix_length};
      REG_PREFIX_NAME_0: prdata = cfg.prefix_name[0];
      REG_PREFIX_NAME_1: prdata = cfg.prefix_name[1];
      REG_PREFIX_NAME_2: prdata = cfg.prefix_name[2];
      REG_PREFIX_NAME_3: prdata = cfg.prefix_name[3];
      REG_PREFIX_NAME_4: prdata = cfg.prefix_name[4];
      REG_PREFIX_NAME_5: prdata = cfg.prefix_name[5];
      default:           prdata = '0;
    endcase
  end

endmodule

[src/nhns_scan.sv]
// hit record parser and nearest hit tracker, one word per strobe
module nhns_scan (
  input  logic                         clk,
  input  logic                         rst,
  input  nhns_pkg::cfg_t               cfg,
  input  logic                         word_valid,
  input  logic [nhns_pkg::WORD_W-1:0]  word,
  input  logic                         word_last,
  output logic                         result_valid,
  output nhns_pkg::result_t            result
);
  import nhns_pkg::*;

  phase_t              phase, phase_next;
  logic [WORD_W-1:0]   names_remaining, names_remaining_next;
  logic [POS_W-1:0]    name_position, name_position_next;
  logic                prefix_mismatch, prefix_mismatch_next;
  logic                depth_name_seen, depth_name_seen_next;
  logic [WORD_W-1:0]   hit_min_depth, hit_min_depth_next;
  logic [WORD_W-1:0]   hit_candidate_name, hit_candidate_name_next;
  logic [WORD_W-1:0]   best_depth, best_depth_next;
  logic [WORD_W-1:0]   best_name, best_name_next;
  logic                any_found, any_found_next;
  logic                judge;
  logic                qualify;
  logic [WORD_W-1:0]   remaining_dec;

  assign remaining_dec = names_remaining - 1'b1;

  always_comb begin
    phase_next              = phase;
    names_remaining_next    = names_remaining;
    name_position_next      = name_position;
    prefix_mismatch_next    = prefix_mismatch;
    depth_name_seen_next    = depth_name_seen;
    hit_min_depth_next      = hit_min_depth;
    hit_candidate_name_next = hit_candidate_name;
    best_depth_next         = best_depth;
    best_name_next          = best_name;
    any_found_next          = any_found;
    judge                   = 1'b0;

    case (phase)
      PH_COUNT: begin
        names_remaining_next    = word;
        name_position_next      = '0;
        prefix_mismatch_next    = 1'b0;
        depth_name_seen_next    = 1'b0;
        hit_candidate_name_next = '0;
        phase_next              = PH_MIN;
      end
      PH_MIN: begin
        hit_min_depth_next = word;
        phase_next         = PH_MAX;
      end
      PH_MAX: begin
        if (names_remaining == '0) begin
          judge = 1'b1;
        end else begin
          phase_next = PH_NAMES;
        end
      end
      PH_NAMES: begin
        if (name_position < cfg.prefix_length) begin
          // positions past the stored prefix can never match
          if (name_position < POS_W'(MAX_PREFIX)) begin
            if (cfg.prefix_name[name_position] != word) prefix_mismatch_next = 1'b1;
          end else begin
            prefix_mismatch_next = 1'b1;
          end
        end else if (name_position == cfg.prefix_length) begin
          hit_candidate_name_next = word;
          depth_name_seen_next    = 1'b1;
        end
        if (name_position != '1) name_position_next = name_position + 1'b1;
        names_remaining_next = remaining_dec;
        if (remaining_dec == '0) judge = 1'b1;
      end
      default: ;
    endcase

    qualify = judge & ~prefix_mismatch_next & depth_name_seen_next &
              (cfg.prefix_length <= POS_W'(MAX_PREFIX));
    if (judge) phase_next = PH_COUNT;
    // strict less-than keeps the earliest hit on equal depth
    if (qualify && (!any_found || hit_min_depth_next < best_depth)) begin
      best_depth_next = hit_min_depth_next;
      best_name_next  = hit_candidate_name_next;
      any_found_next  = 1'b1;
    end

    result_valid         = word_valid & word_last;
    result.match_found   = any_found_next;
    result.selected_name = any_found_next ? best_name_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_COUNT;
      names_remaining    <= '0;
      name_position      <= '0;
      prefix_mismatch    <= 1'b0;
      depth_name_seen    <= 1'b0;
      hit_min_depth      <= '0;
      hit_candidate_name <= '0;
      best_depth         <= '0;
      best_name          <= '0;
      any_found          <= 1'b0;
    end else if (word_valid) begin
      if (word_last) begin
        phase              <= PH_COUNT;
        names_remaining    <= '0;
        name_position      <= '0;
        prefix_mismatch    <= 1'b0;
        depth_name_seen    <= 1'b0;
        hit_min_depth      <= '0;
        hit_candidate_name <= '0;
        best_depth         <= '0;
        best_name          <= '0;
        any_found          <= 1'b0;
      end else begin
        phase              <= phase_next;
        names_remaining    <= names_remaining_next;
        name_position      <= name_position_next;
        prefix_mismatch    <= prefix_mismatch_next;
        depth_name_seen    <= depth_name_seen_next;
        hit_min_depth      <= hit_min_depth_next;
        hit_candidate_name <= hit_candidate_name_next;
        best_depth         <= best_depth_next;
        best_name          <= best_name_next;
        any_found          <= any_found_next;
      end
    end
  end

endmodule

[src/nhns_out.sv]
// result register driving the master stream
module nhns_out (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  nhns_pkg::result_t            result,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [nhns_pkg::WORD_W-1:0]  m_tdata,
  output logic                         m_tuser
);
  import nhns_pkg::*;

  logic m_tvalid_next;

  assign m_tvalid_next = load | (m_tvalid & ~m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= result.selected_name;
      m_tuser <= result.match_found;
    end
  end

endmodule

[test/tb_nearest_hit_name_selector.sv]
// self-checking testbench for the nearest hit name selector: stream words in, compare selections
module tb_nearest_hit_name_selector;
  timeunit 1ns;
  timeprecision 1ps;

  import nhns_pkg::*;

  // generous bound, far above the slowest legal run with every gap and stall at its longest
  localparam int CYCLE_LIMIT = 600000;
  // words queued per random phase
  localparam int PHASE_WORDS = 200;
  localparam int N_PHASES    = 10;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } buffer_word_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [WORD_W-1:0]  s_tdata = '0;
  logic               s_tlast = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [WORD_W-1:0]  m_tdata;
  logic               m_tuser;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  nearest_hit_name_selector u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [31:0] buffer_word
    .s_tlast  (s_tlast),   // end_of_buffer
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [31:0] selected_name
    .m_tuser  (m_tuser),   // [0] match_found
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // words waiting for the driver, and selections the block still owes us
  buffer_word_t  words_to_send[$];
  result_t       selections_due[$];
  logic [WORD_W-1:0] buf_q[$];   // scratch for building one buffer

  int  mismatches = 0;
  int  cycles = 0;
  bit  calm = 1'b0;              // phase with no idling on either side
  int  send_gap = 0;
  int  ready_hold = 0;

  // testbench copy of the prefix registers
  logic [POS_W-1:0]  cfg_len = '0;
  logic [WORD_W-1:0] cfg_name [MAX_PREFIX] = '{default: '0};

  // scan state of the hit tracker
  phase_t            scan_phase = PH_COUNT;
  logic [WORD_W-1:0] names_left = '0;
  logic [POS_W-1:0]  name_pos = '0;
  logic              prefix_bad = 1'b0;
  logic              cand_seen = 1'b0;
  logic [WORD_W-1:0] hit_depth = '0;
  logic [WORD_W-1:0] cand_name = '0;
  logic [WORD_W-1:0] best_depth = '0;
  logic [WORD_W-1:0] best_name = '0;
  logic              any_hit = 1'b0;

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("%0t mismatch on %s: got %h want %h", $time, what, got, want);
    mismatches++;
  endtask

  // a finished record competes for nearest; strict less-than keeps the earliest on ties
  task automatic close_record();
    if (!prefix_bad && cand_seen && cfg_len <= MAX_PREFIX) begin
      if (!any_hit || hit_depth < best_depth) begin
        best_depth = hit_depth;
        best_name  = cand_name;
        any_hit    = 1'b1;
      end
    end
    scan_phase = PH_COUNT;
  endtask

  // fold one accepted word into the scan; the final word yields a selection
  task automatic track_nearest_hit(input logic [WORD_W-1:0] word, input logic last);
    case (scan_phase)
      PH_COUNT: begin
        names_left = word;
        name_pos   = '0;
        prefix_bad = 1'b0;
        cand_seen  = 1'b0;
        cand_name  = '0;
        scan_phase = PH_MIN;
      end
      PH_MIN: begin
        hit_depth  = word;
        scan_phase = PH_MAX;
      end
      PH_MAX: begin
        // empty record ends on its max depth word and never qualifies
        if (names_left == 0) close_record();
        else scan_phase = PH_NAMES;
      end
      default: begin
        if (name_pos < cfg_len) begin
          // positions past the register file can never match
          if (name_pos < MAX_PREFIX) begin
            if (cfg_name[name_pos] != word) prefix_bad = 1'b1;
          end else begin
            prefix_bad = 1'b1;
          end
        end else if (name_pos == cfg_len) begin
          cand_name = word;
          cand_seen = 1'b1;
        end
        // names past the candidate are swallowed, position saturates
        if (name_pos != 3'd7) name_pos = name_pos + 1'b1;
        names_left = names_left - 1'b1;
        if (names_left == 0) close_record();
      end
    endcase
    if (last) begin
      // an unfinished record is simply dropped with the rest of the scan
      selections_due.push_back('{selected_name: any_hit ? best_name : '0,
                                 match_found: any_hit});
      scan_phase = PH_COUNT;
      names_left = '0;
      name_pos   = '0;
      prefix_bad = 1'b0;
      cand_seen  = 1'b0;
      hit_depth  = '0;
      cand_name  = '0;
      best_depth = '0;
      best_name  = '0;
      any_hit    = 1'b0;
    end
  endtask

  // mostly back to back, some short gaps, rare long ones
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // stream driver: present the next queued word, hold it until the transfer
  always @(posedge clk) begin : drive_words
    buffer_word_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) track_nearest_hit(s_tdata, s_tlast);
      if (s_tvalid && !s_tready) begin
        // stalled: keep the word on the bus
      end else if (send_gap > 0) begin
        s_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (words_to_send.size() != 0) begin
        it = words_to_send.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= it.word;
        s_tlast  <= it.last;
        send_gap <= pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result monitor: check each selection against the oldest one due, then pick ready
  always @(posedge clk) begin : watch_selections
    result_t want;
    int n;
    if (!rst && m_tvalid && m_tready) begin
      if (selections_due.size() == 0) begin
        report_mismatch("unexpected selection", m_tdata, '0);
      end else begin
        want = selections_due.pop_front();
        if (m_tdata !== want.selected_name)
          report_mismatch("selected_name", m_tdata, want.selected_name);
        if (m_tuser !== want.match_found)
          report_mismatch("match_found", WORD_W'(m_tuser), WORD_W'(want.match_found));
      end
    end
    if (ready_hold > 0) begin
      m_tready   <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      n = pick_gap();
      m_tready   <= (n == 0);
      ready_hold <= (n > 0) ? n - 1 : 0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t timeout with %0d selections due", $time, selections_due.size());
      $display("tb_nearest_hit_name_selector: done, errors");
      $finish;
    end
  end

  // apb write: setup cycle, access cycle, register lands on the access edge
  task automatic write_reg(input logic [2:0] idx, input logic [WORD_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx) << 2;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_PREFIX_LENGTH) cfg_len = val[POS_W-1:0];
    else cfg_name[idx - REG_PREFIX_NAME_0] = val;
    @(negedge clk);
  endtask

  task automatic add_word(input logic [WORD_W-1:0] w, input logic last);
    words_to_send.push_back('{word: w, last: last});
  endtask

  // block drained: nothing queued, nothing on the bus, nothing owed, pipeline flushed
  task automatic wait_drained();
    @(negedge clk);
    while (words_to_send.size() != 0 || s_tvalid || selections_due.size() != 0)
      @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  function automatic logic [WORD_W-1:0] pick_depth();
    int r;
    r = $urandom_range(0, 99);
    // small values and the extremes make ties common
    if (r < 12) return '0;
    if (r < 24) return '1;
    if (r < 50) return $urandom_range(0, 15);
    return $urandom;
  endfunction

  function automatic logic [WORD_W-1:0] pick_name(input int p);
    if (p < cfg_len && p < MAX_PREFIX && $urandom_range(0, 99) < 90) return cfg_name[p];
    return $urandom;
  endfunction

  // one hit record into the scratch buffer; a cut record stops short of its end
  task automatic make_record(input bit cut);
    int r;
    int keep;
    logic [WORD_W-1:0] count;
    logic [WORD_W-1:0] w;
    r = $urandom_range(0, 99);
    if (cut && r < 30) count = $urandom | 32'h8000_0000;
    else if (r < 70) count = cfg_len + 1 + $urandom_range(0, 3);
    else if (r < 82) count = $urandom_range(0, cfg_len);
    else count = $urandom_range(0, 12);
    if (count > 64) keep = 3 + $urandom_range(0, 5);
    else if (cut) keep = $urandom_range(1, count + 2);
    else keep = count + 3;
    for (int i = 0; i < keep; i++) begin
      if (i == 0) w = count;
      else if (i < 3) w = pick_depth();
      else w = pick_name(i - 3);
      buf_q.push_back(w);
    end
  endtask

  // one whole buffer: mostly well-formed records, sometimes a cut tail, sometimes noise
  task automatic make_buffer();
    int n;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) buf_q.push_back($urandom);
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) make_record(1'b0);
      if ($urandom_range(0, 3) == 0) make_record(1'b1);
    end
    foreach (buf_q[i]) add_word(buf_q[i], i == buf_q.size() - 1);
    buf_q.delete();
  endtask

  function automatic logic [WORD_W-1:0] pick_prefix_name();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  initial begin
    int phase_len [N_PHASES] = '{0, 6, 7, 1, 3, 6, 2, 5, 4, 0};
    logic [WORD_W-1:0] dir_names [MAX_PREFIX] =
      '{32'hffff_ffff, 32'h0, 32'h5a5a_5a5a, 32'ha5a5_a5a5, 32'h1, 32'h8000_0000};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset prefix (length 0): a lone final word gives no hit
    add_word(32'hffff_ffff, 1'b1);
    // first hit at max depth, a tie that must not replace it, then a cut record
    // with a smaller depth that must be ignored
    add_word(32'd1, 1'b0);
    add_word(32'hffff_ffff, 1'b0);
    add_word(32'd0, 1'b0);
    add_word(32'hffff_ffff, 1'b0);
    add_word(32'd2, 1'b0);
    add_word(32'hffff_ffff, 1'b0);
    add_word(32'd7, 1'b0);
    add_word(32'h1234_5678, 1'b0);
    add_word(32'd0, 1'b0);
    add_word(32'd3, 1'b0);
    add_word(32'd5, 1'b0);
    add_word(32'd5, 1'b0);
    add_word(32'd9, 1'b1);
    wait_drained();

    // full-length prefix: empty record at depth 0 must not win over the real hit
    write_reg(REG_PREFIX_LENGTH, MAX_PREFIX);
    for (int i = 0; i < MAX_PREFIX; i++) write_reg(3'(REG_PREFIX_NAME_0 + i), dir_names[i]);
    add_word(32'd0, 1'b0);
    add_word(32'd0, 1'b0);
    add_word(32'd0, 1'b0);
    add_word(32'd7, 1'b0);
    add_word(32'd1, 1'b0);
    add_word(32'd0, 1'b0);
    for (int i = 0; i < MAX_PREFIX; i++) add_word(dir_names[i], 1'b0);
    add_word(32'h8000_0001, 1'b1);
    wait_drained();

    // random phases, each with a fresh prefix; length 7 is past the limit
    for (int ph = 0; ph < N_PHASES; ph++) begin
      calm = ($urandom_range(0, 3) == 0);
      write_reg(REG_PREFIX_LENGTH, phase_len[ph]);
      for (int i = 0; i < MAX_PREFIX; i++)
        write_reg(3'(REG_PREFIX_NAME_0 + i), pick_prefix_name());
      while (words_to_send.size() < PHASE_WORDS) make_buffer();
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("tb_nearest_hit_name_selector: done, clean");
    end else begin
      $display("tb_nearest_hit_name_selector: done, errors");
    end
    $finish;
  end

endmodule
